// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the packetizer modules.
// Each macro expects clk and rst to be visible in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, suspended while reset is high.
`define RHP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checked on every rising edge, reset included.
`define RHP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ----- rtl/rhp_pkg.sv -----
package rhp_pkg;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_SSRC         = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_TYPE = 2'd2;

  // Register reset values and limits.
  localparam logic [13:0] MAXPAY_RESET = 14'd1400;
  localparam logic [13:0] MAXPAY_MIN   = 14'd3;
  localparam logic [6:0]  PT_RESET     = 7'd96;

  // RTP and FU-A constants.
  localparam logic [7:0] RTP_V2_BYTE = 8'h80;
  localparam logic [7:0] NRI_MASK    = 8'hE0;
  localparam logic [7:0] TYPE_MASK   = 8'h1F;
  localparam logic [7:0] FU_A_TYPE   = 8'd28;

  // Byte positions inside the packet serializer.
  localparam int POS_W = 4;
  localparam logic [POS_W-1:0] POS_FIRST    = 4'd0;
  localparam logic [POS_W-1:0] POS_HDR_LAST = 4'd11;
  localparam logic [POS_W-1:0] POS_FU_IND   = 4'd12;
  localparam logic [POS_W-1:0] POS_FU_HDR   = 4'd13;
  localparam logic [POS_W-1:0] POS_DATA     = 4'd14;

  // One NAL unit byte request.
  typedef struct packed {
    logic [7:0]  nalu_byte;
    logic        nalu_start;
    logic [23:0] nalu_length;
    logic [31:0] frame_timestamp;
    logic        last_unit_of_frame;
  } rhp_in_t;

  // One RTP packet byte request.
  typedef struct packed {
    logic [7:0] packet_byte;
    logic       packet_start;
    logic       packet_end;
  } rhp_out_t;

  // What one accepted unit byte turns into on the output.
  typedef struct packed {
    logic        hdr;       // 12-byte RTP header goes first
    logic        fu;        // FU indicator and FU header follow the RTP header
    logic        marker;
    logic [15:0] seq;
    logic [31:0] ts;
    logic [7:0]  fu_ind;
    logic [7:0]  fu_hdr;
    logic [7:0]  data;
    logic        data_end;  // data byte closes the packet
  } rhp_desc_t;

endpackage

// ----- rtl/h264_rtp_packetizer.sv -----
// H.264 RTP packetizer, single NAL unit and FU-A modes.
// Input channel nalu_valid/nalu_stall/nalu carries one NAL unit byte per request;
// length, timestamp and last-of-frame are taken from the request with nalu_start.
// Output channel pkt_valid/pkt_stall/pkt carries RTP packet bytes, with
// packet_start on the first header byte and packet_end on the last payload byte.
// Registers are written through cfg_we/cfg_index/cfg_data while the block is idle;
// the user is bound to this, which the block does not enforce. Indexes: 0 ssrc,
// 1 max_payload, 2 payload_type; other indexes are ignored. The first output byte
// of a request is valid in the cycle after it is accepted. A byte opening a single
// packet follows the 12 header bytes, one opening an FU-A fragment follows the
// header, FU indicator and FU header; others go alone, one byte per cycle while
// the receiver does not stall. The kept NAL header of a fragmented unit and
// ignored bytes send nothing. The next request is accepted in the cycle the last
// byte of the current one leaves. Reset clears the sequence number and unit state,
// loads register defaults and holds nalu_stall high. When the receiver stalls, the
// current byte holds and nalu_stall rises once the serializer has nothing free.
module h264_rtp_packetizer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [rhp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rhp_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              nalu_valid,
  output logic                              nalu_stall,
  input  rhp_pkg::rhp_in_t                  nalu,
  output logic                              pkt_valid,
  input  logic                              pkt_stall,
  output rhp_pkg::rhp_out_t                 pkt
);
  import rhp_pkg::*;

  logic [31:0] ssrc;
  logic [13:0] max_payload;
  logic [6:0]  payload_type;

  logic        accept;
  logic        ready;
  rhp_desc_t   desc;
  logic        desc_valid;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ssrc         <= 32'd0;
      max_payload  <= MAXPAY_RESET;
      payload_type <= PT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SSRC:         ssrc         <= cfg_data;
        CFG_MAX_PAYLOAD:  max_payload  <= cfg_data[13:0];
        CFG_PAYLOAD_TYPE: payload_type <= cfg_data[6:0];
        default:          ;
      endcase
    end
  end

  // Input handshake.
  assign nalu_stall = rst || !ready;
  assign accept     = nalu_valid && !nalu_stall;

  rhp_core u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .nalu        (nalu),
    .max_payload (max_payload),
    .desc        (desc),
    .desc_valid  (desc_valid)
  );

  rhp_serializer u_ser (
    .clk          (clk),
    .rst          (rst),
    .load         (accept && desc_valid),
    .desc         (desc),
    .ready        (ready),
    .ssrc         (ssrc),
    .payload_type (payload_type),
    .pkt_valid    (pkt_valid),
    .pkt_stall    (pkt_stall),
    .pkt          (pkt)
  );

endmodule

// ----- rtl/rhp_core.sv -----
`include "assert_macros.svh"

module rhp_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  rhp_pkg::rhp_in_t nalu,
  input  logic [13:0]      max_payload,
  output rhp_pkg::rhp_desc_t desc,
  output logic             desc_valid
);
  import rhp_pkg::*;

  logic [15:0] seq, seq_next;
  logic [23:0] left, left_next;
  logic [13:0] frag_rem, frag_rem_next;
  logic        fragmenting, fragmenting_next;
  logic        first_frag, first_frag_next;
  logic        unit_last, unit_last_next;
  logic [7:0]  hdr_saved, hdr_saved_next;
  logic [31:0] cur_ts, cur_ts_next;

  logic [13:0] mp_eff;
  logic [13:0] frag_max;
  logic        left_fits;
  logic [13:0] chunk;
  logic [13:0] rem_dec;

  // Effective payload limit and the size of a new fragment.
  assign mp_eff    = (max_payload < MAXPAY_MIN) ? MAXPAY_MIN : max_payload;
  assign frag_max  = mp_eff - 14'd2;
  assign left_fits = (left <= {10'd0, frag_max});
  assign chunk     = left_fits ? left[13:0] : frag_max;
  assign rem_dec   = (frag_rem == 14'd0) ? (chunk - 14'd1) : (frag_rem - 14'd1);

  // Next state and output descriptor for the request at the input.
  always_comb begin
    seq_next         = seq;
    left_next        = left;
    frag_rem_next    = frag_rem;
    fragmenting_next = fragmenting;
    first_frag_next  = first_frag;
    unit_last_next   = unit_last;
    hdr_saved_next   = hdr_saved;
    cur_ts_next      = cur_ts;
    desc_valid       = 1'b0;
    desc.hdr         = 1'b0;
    desc.fu          = 1'b0;
    desc.marker      = 1'b0;
    desc.seq         = seq;
    desc.ts          = cur_ts;
    desc.fu_ind      = (hdr_saved & NRI_MASK) | FU_A_TYPE;
    desc.fu_hdr      = {first_frag, left_fits, 1'b0, hdr_saved[4:0]};
    desc.data        = nalu.nalu_byte;
    desc.data_end    = 1'b0;

    if (nalu.nalu_start) begin
      cur_ts_next    = nalu.frame_timestamp;
      unit_last_next = nalu.last_unit_of_frame;
      frag_rem_next  = 14'd0;
      desc.ts        = nalu.frame_timestamp;
      if (nalu.nalu_length == 24'd0) begin
        left_next        = 24'd0;
        fragmenting_next = 1'b0;
      end else begin
        left_next = nalu.nalu_length - 24'd1;
        if (nalu.nalu_length <= {10'd0, mp_eff}) begin
          // Whole unit fits in a single packet.
          fragmenting_next = 1'b0;
          desc_valid       = 1'b1;
          desc.hdr         = 1'b1;
          desc.marker      = nalu.last_unit_of_frame;
          desc.data_end    = (nalu.nalu_length == 24'd1);
          seq_next         = seq + 16'd1;
        end else begin
          // The NAL header is kept for the FU bytes and not sent.
          fragmenting_next = 1'b1;
          first_frag_next  = 1'b1;
          hdr_saved_next   = nalu.nalu_byte;
        end
      end
    end else if (left != 24'd0) begin
      left_next  = left - 24'd1;
      desc_valid = 1'b1;
      if (!fragmenting) begin
        desc.data_end = (left == 24'd1);
      end else begin
        if (frag_rem == 14'd0) begin
          // Open a new fragment.
          desc.hdr        = 1'b1;
          desc.fu         = 1'b1;
          desc.marker     = left_fits && unit_last;
          seq_next        = seq + 16'd1;
          first_frag_next = 1'b0;
        end
        frag_rem_next = rem_dec;
        desc.data_end = (rem_dec == 14'd0);
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      seq         <= 16'd0;
      left        <= 24'd0;
      frag_rem    <= 14'd0;
      fragmenting <= 1'b0;
      first_frag  <= 1'b0;
      unit_last   <= 1'b0;
    end else if (accept) begin
      seq         <= seq_next;
      left        <= left_next;
      frag_rem    <= frag_rem_next;
      fragmenting <= fragmenting_next;
      first_frag  <= first_frag_next;
      unit_last   <= unit_last_next;
    end
  end

  // Latched unit header byte and timestamp.
  always_ff @(posedge clk) begin
    if (accept) begin
      hdr_saved <= hdr_saved_next;
      cur_ts    <= cur_ts_next;
    end
  end

  `RHP_ASSERT(a_seq_step, accept && desc_valid && desc.hdr |=> seq == $past(seq) + 16'd1,
    "sequence number did not advance with a packet header")
  `RHP_ASSERT(a_rem_in_unit, frag_rem <= left[13:0] || left > 24'd16383,
    "fragment holds more bytes than the unit has left")
  `RHP_ASSERT(a_rem_idle, !fragmenting |-> frag_rem == 14'd0,
    "fragment count set outside fragmentation")

endmodule

// ----- rtl/rhp_serializer.sv -----
`include "assert_macros.svh"

module rhp_serializer (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  rhp_pkg::rhp_desc_t desc,
  output logic               ready,
  input  logic [31:0]        ssrc,
  input  logic [6:0]         payload_type,
  output logic               pkt_valid,
  input  logic               pkt_stall,
  output rhp_pkg::rhp_out_t  pkt
);
  import rhp_pkg::*;

  logic            busy;
  logic [POS_W-1:0] pos;
  rhp_desc_t       desc_q;

  // A new descriptor may enter as the last byte of the current one leaves.
  assign ready     = !busy || (pos == POS_DATA && !pkt_stall);
  assign pkt_valid = busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= POS_FIRST;
    end else if (load) begin
      busy <= 1'b1;
      pos  <= desc.hdr ? POS_FIRST : POS_DATA;
    end else if (busy && !pkt_stall) begin
      if (pos == POS_DATA) begin
        busy <= 1'b0;
      end else if (pos == POS_HDR_LAST && !desc_q.fu) begin
        pos <= POS_DATA;
      end else begin
        pos <= pos + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      desc_q <= desc;
    end
  end

  // Byte select over header, FU bytes and the unit byte.
  always_comb begin
    case (pos)
      4'd0:       pkt.packet_byte = RTP_V2_BYTE;
      4'd1:       pkt.packet_byte = {desc_q.marker, payload_type};
      4'd2:       pkt.packet_byte = desc_q.seq[15:8];
      4'd3:       pkt.packet_byte = desc_q.seq[7:0];
      4'd4:       pkt.packet_byte = desc_q.ts[31:24];
      4'd5:       pkt.packet_byte = desc_q.ts[23:16];
      4'd6:       pkt.packet_byte = desc_q.ts[15:8];
      4'd7:       pkt.packet_byte = desc_q.ts[7:0];
      4'd8:       pkt.packet_byte = ssrc[31:24];
      4'd9:       pkt.packet_byte = ssrc[23:16];
      4'd10:      pkt.packet_byte = ssrc[15:8];
      POS_HDR_LAST: pkt.packet_byte = ssrc[7:0];
      POS_FU_IND: pkt.packet_byte = desc_q.fu_ind;
      POS_FU_HDR: pkt.packet_byte = desc_q.fu_hdr;
      default:    pkt.packet_byte = desc_q.data;
    endcase
  end

  assign pkt.packet_start = (pos == POS_FIRST);
  assign pkt.packet_end   = (pos == POS_DATA) && desc_q.data_end;

  `RHP_ASSERT(a_load_ready, load |-> ready,
    "descriptor loaded while a packet byte is still pending")
  `RHP_ASSERT(a_start_hdr, pkt_valid && pkt.packet_start |-> desc_q.hdr,
    "packet start without a header")
  `RHP_ASSERT(a_fu_skip,
    busy && !pkt_stall && pos == POS_HDR_LAST && !desc_q.fu |=> pos == POS_DATA,
    "single packet did not skip the FU bytes")
  `RHP_ASSERT_ALWAYS(a_reset_idle, rst |=> !pkt_valid,
    "output valid right after reset")

endmodule

// ----- tb/tb_h264_rtp_packetizer.sv -----
module tb_h264_rtp_packetizer;
  import rhp_pkg::*;

  localparam logic [7:0] MARKER_BIT   = 8'h80;
  localparam logic [7:0] FU_START_BIT = 8'h80;
  localparam logic [7:0] FU_END_BIT   = 8'h40;
  localparam int CYCLE_LIMIT      = 600000;
  localparam int SETTLE_CYCLES    = 24;
  localparam int LONG_HOLD_CYCLES = 300;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  nalu_valid;
  logic                  nalu_stall;
  rhp_in_t               nalu;
  logic                  pkt_valid;
  logic                  pkt_stall;
  rhp_out_t              pkt;

  h264_rtp_packetizer dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .nalu_valid (nalu_valid),
    .nalu_stall (nalu_stall),
    .nalu       (nalu),
    .pkt_valid  (pkt_valid),
    .pkt_stall  (pkt_stall),
    .pkt        (pkt)
  );

  // Register copies and packetizer state as the block should hold them.
  logic [31:0] cfg_ssrc;
  logic [13:0] cfg_max_payload;
  logic [6:0]  cfg_pt;
  logic [15:0] seq_num;
  logic [23:0] unit_offset;
  logic [13:0] frag_left;
  logic [7:0]  saved_nal_hdr;
  logic        in_fu;
  logic [31:0] cur_ts;
  logic [23:0] unit_len;
  logic        unit_is_last;

  // Packet bytes still owed by the block, oldest first.
  rhp_out_t pkt_bytes_due[$];

  int error_count = 0;
  int cycle_count = 0;
  bit tx_idle_on  = 1'b0;
  bit rx_idle_on  = 1'b0;
  bit hold_req    = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void push_byte(input logic [7:0] b, input logic s, input logic e);
    rhp_out_t r;
    r.packet_byte  = b;
    r.packet_start = s;
    r.packet_end   = e;
    pkt_bytes_due  = {pkt_bytes_due, r};
  endfunction

  // Twelve header bytes: version, marker and type, sequence, timestamp, source.
  function automatic void push_rtp_header(input logic marker);
    push_byte(RTP_V2_BYTE, 1'b1, 1'b0);
    push_byte((marker ? MARKER_BIT : 8'h00) | {1'b0, cfg_pt}, 1'b0, 1'b0);
    push_byte(seq_num[15:8], 1'b0, 1'b0);
    push_byte(seq_num[7:0], 1'b0, 1'b0);
    push_byte(cur_ts[31:24], 1'b0, 1'b0);
    push_byte(cur_ts[23:16], 1'b0, 1'b0);
    push_byte(cur_ts[15:8], 1'b0, 1'b0);
    push_byte(cur_ts[7:0], 1'b0, 1'b0);
    push_byte(cfg_ssrc[31:24], 1'b0, 1'b0);
    push_byte(cfg_ssrc[23:16], 1'b0, 1'b0);
    push_byte(cfg_ssrc[15:8], 1'b0, 1'b0);
    push_byte(cfg_ssrc[7:0], 1'b0, 1'b0);
    seq_num = seq_num + 16'd1;
  endfunction

  // Works out the packet bytes that one accepted unit byte causes.
  function automatic void predict_packet_bytes(input rhp_in_t it);
    int unsigned limit;
    int unsigned left;
    int unsigned chunk;
    logic        first;
    logic        last;
    logic [7:0]  fu_hdr;
    limit = (cfg_max_payload < MAXPAY_MIN) ? MAXPAY_MIN : cfg_max_payload;
    if (it.nalu_start) begin
      unit_len     = it.nalu_length;
      cur_ts       = it.frame_timestamp;
      unit_is_last = it.last_unit_of_frame;
      frag_left    = 14'd0;
      if (unit_len == 24'd0) begin
        unit_offset = 24'd0;
        in_fu       = 1'b0;
      end else begin
        unit_offset = 24'd1;
        if (unit_len <= limit) begin
          in_fu = 1'b0;
          push_rtp_header(unit_is_last);
          push_byte(it.nalu_byte, 1'b0, unit_len == 24'd1);
        end else begin
          // The NAL header is held back and rebuilt in every FU-A fragment.
          in_fu         = 1'b1;
          saved_nal_hdr = it.nalu_byte;
        end
      end
    end else if (unit_offset != 24'd0 && unit_offset < unit_len) begin
      if (!in_fu) begin
        push_byte(it.nalu_byte, 1'b0, unit_offset + 24'd1 == unit_len);
      end else begin
        if (frag_left == 14'd0) begin
          left   = unit_len - unit_offset;
          chunk  = (left < limit - 2) ? left : limit - 2;
          first  = unit_offset == 24'd1;
          last   = unit_offset + chunk >= unit_len;
          fu_hdr = (saved_nal_hdr & TYPE_MASK) | (first ? FU_START_BIT : 8'h00) |
                   (last ? FU_END_BIT : 8'h00);
          push_rtp_header(last && unit_is_last);
          push_byte((saved_nal_hdr & NRI_MASK) | FU_A_TYPE, 1'b0, 1'b0);
          push_byte(fu_hdr, 1'b0, 1'b0);
          frag_left = chunk[13:0];
        end
        frag_left = frag_left - 14'd1;
        push_byte(it.nalu_byte, 1'b0, frag_left == 14'd0);
      end
      unit_offset = unit_offset + 24'd1;
    end
  endfunction

  function automatic rhp_in_t make_nalu(input logic [7:0] b, input logic s,
                                        input logic [23:0] len, input logic [31:0] ts,
                                        input logic last);
    rhp_in_t it;
    it.nalu_byte          = b;
    it.nalu_start         = s;
    it.nalu_length        = len;
    it.frame_timestamp    = ts;
    it.last_unit_of_frame = last;
    return it;
  endfunction

  function automatic rhp_in_t random_nalu();
    rhp_in_t     it;
    logic [31:0] rnd;
    rnd                   = $urandom;
    it.nalu_byte          = rnd[7:0];
    it.nalu_start         = rnd[8];
    it.last_unit_of_frame = rnd[9];
    rnd                   = $urandom;
    it.nalu_length        = rnd[23:0];
    it.frame_timestamp    = $urandom;
    return it;
  endfunction

  // Offers one request and waits for the handshake. Valid stays high afterwards,
  // so the caller either sends again at once or drops it.
  task automatic send_nalu(input rhp_in_t item);
    int gap;
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 19);
      nalu_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    nalu_valid <= 1'b1;
    nalu       <= item;
    @(posedge clk);
    while (nalu_stall) @(posedge clk);
    predict_packet_bytes(item);
  endtask

  // Sends the first nbytes of a unit of length len with random content.
  task automatic send_unit(input int unsigned len, input int unsigned nbytes,
                           input logic last);
    rhp_in_t it;
    it                    = random_nalu();
    it.nalu_start         = 1'b1;
    it.nalu_length        = len[23:0];
    it.last_unit_of_frame = last;
    send_nalu(it);
    for (int i = 1; i < nbytes; i++) begin
      it            = random_nalu();
      it.nalu_start = 1'b0;
      send_nalu(it);
    end
  endtask

  task automatic wait_for_drain();
    nalu_valid <= 1'b0;
    @(posedge clk);
    while (pkt_bytes_due.size() != 0) @(posedge clk);
  endtask

  // Lets the block go idle; bytes that cause no output may still be in flight.
  task automatic settle();
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_SSRC:         cfg_ssrc = val;
      CFG_MAX_PAYLOAD:  cfg_max_payload = val[13:0];
      CFG_PAYLOAD_TYPE: cfg_pt = val[6:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [31:0] ssrc, input logic [13:0] max_pay,
                            input logic [6:0] pt);
    settle();
    write_reg(CFG_SSRC, ssrc);
    write_reg(CFG_MAX_PAYLOAD, {18'd0, max_pay});
    write_reg(CFG_PAYLOAD_TYPE, {25'd0, pt});
  endtask

  // Register defaults: one-byte and two-byte units at the field extremes.
  task automatic test_single_defaults();
    send_nalu(make_nalu(8'hFF, 1'b1, 24'd1, 32'hFFFF_FFFF, 1'b1));
    send_nalu(make_nalu(8'h00, 1'b1, 24'd2, 32'h0000_0000, 1'b0));
    send_nalu(make_nalu(8'h5A, 1'b0, 24'hFF_FFFF, 32'hFFFF_FFFF, 1'b1));
  endtask

  // A zero-length start and a byte with no open unit are both dropped.
  task automatic test_ignored_bytes();
    send_nalu(make_nalu(8'h55, 1'b1, 24'd0, 32'h1234_5678, 1'b1));
    send_nalu(make_nalu(8'hAA, 1'b0, 24'd9, 32'h8765_4321, 1'b0));
  endtask

  // FU-A with two bytes per fragment, then a stray byte after the unit ends.
  task automatic test_fragmentation();
    rhp_in_t it;
    set_config(32'hFFFF_FFFF, 14'd4, 7'd127);
    send_nalu(make_nalu(8'hE5, 1'b1, 24'd7, 32'hA5A5_5A5A, 1'b1));
    send_nalu(make_nalu(8'h00, 1'b0, 24'd0, 32'h0, 1'b0));
    send_nalu(make_nalu(8'hFF, 1'b0, 24'd0, 32'h0, 1'b0));
    for (int i = 0; i < 4; i++) begin
      it            = random_nalu();
      it.nalu_start = 1'b0;
      send_nalu(it);
    end
    send_nalu(make_nalu(8'h3C, 1'b0, 24'd0, 32'h0, 1'b0));
  endtask

  // A limit below the minimum acts as three; a huge unit is cut short by a
  // new start, and a unit exactly at the limit goes out whole.
  task automatic test_tiny_limit_and_abandon();
    set_config(32'h0000_0000, 14'd0, 7'd0);
    send_unit(5, 5, 1'b0);
    send_unit(24'hFF_FFFF, 3, 1'b1);
    send_unit(3, 3, 1'b1);
  endtask

  // The receiver holds off long enough for the block to stall its input.
  task automatic test_long_hold();
    set_config($urandom, 14'd6, PT_RESET);
    hold_req = 1'b1;
    send_unit(40, 40, 1'b1);
  endtask

  // The sender waits for every packet byte before each new unit.
  task automatic test_drained_pause();
    int unsigned len;
    for (int i = 0; i < 3; i++) begin
      len = $urandom_range(1, 12);
      send_unit(len, len, 1'b0);
      wait_for_drain();
    end
  endtask

  // Random units of mostly short length with some noise mixed in.
  task automatic test_random_traffic(input int n_items, input int unsigned mp_lo,
                                     input int unsigned mp_hi);
    int unsigned mp;
    int unsigned eff;
    int unsigned len;
    int          sent;
    int          pick;
    rhp_in_t     it;
    mp = $urandom_range(mp_lo, mp_hi);
    set_config($urandom, mp[13:0], 7'($urandom_range(0, 127)));
    eff  = (mp < 3) ? 3 : mp;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 19);
      if (pick < 15) begin
        case ($urandom_range(0, 3))
          0, 1: len = $urandom_range(1, 12);
          2: len = (eff <= 40) ? eff - 1 + $urandom_range(0, 2) : $urandom_range(1, 30);
          default: len = $urandom_range(1, 30);
        endcase
        send_unit(len, len, 1'($urandom_range(0, 1)));
        sent += len;
      end else if (pick < 17) begin
        it            = random_nalu();
        it.nalu_start = 1'b0;
        send_nalu(it);
      end else if (pick == 17) begin
        it             = random_nalu();
        it.nalu_start  = 1'b1;
        it.nalu_length = 24'd0;
        send_nalu(it);
      end else begin
        len = $urandom_range(1, 6);
        send_unit($urandom_range(eff + 1, 24'hFF_FFFF), len, 1'($urandom_range(0, 1)));
        sent += len;
      end
    end
  endtask

  // Output checker: every accepted packet byte against the oldest one owed.
  initial begin : pkt_checker
    rhp_out_t want;
    forever begin
      @(posedge clk);
      if (!rst && pkt_valid && !pkt_stall) begin
        if (pkt_bytes_due.size() == 0) begin
          $error("unexpected packet byte %0h", pkt.packet_byte);
          error_count++;
        end else begin
          want = pkt_bytes_due.pop_front();
          if (pkt.packet_byte !== want.packet_byte) begin
            $error("packet_byte expected %0h actual %0h", want.packet_byte, pkt.packet_byte);
            error_count++;
          end
          if (pkt.packet_start !== want.packet_start) begin
            $error("packet_start expected %0h actual %0h", want.packet_start,
                   pkt.packet_start);
            error_count++;
          end
          if (pkt.packet_end !== want.packet_end) begin
            $error("packet_end expected %0h actual %0h", want.packet_end, pkt.packet_end);
            error_count++;
          end
        end
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold when requested.
  initial begin : pkt_receiver
    int burst_left;
    int hold_left;
    burst_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = LONG_HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pkt_stall <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        pkt_stall <= 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        burst_left = $urandom_range(1, 19) - 1;
        pkt_stall <= 1'b1;
      end else begin
        pkt_stall <= 1'b0;
      end
    end
  end

  // Watchdog on the whole run.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin : main_seq
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = CFG_SSRC;
    cfg_data   = '0;
    nalu_valid = 1'b0;
    nalu       = '0;
    pkt_stall  = 1'b0;

    cfg_ssrc        = 32'd0;
    cfg_max_payload = MAXPAY_RESET;
    cfg_pt          = PT_RESET;
    seq_num         = 16'd0;
    unit_offset     = 24'd0;
    frag_left       = 14'd0;
    saved_nal_hdr   = 8'd0;
    in_fu           = 1'b0;
    cur_ts          = 32'd0;
    unit_len        = 24'd0;
    unit_is_last    = 1'b0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_single_defaults();
    test_ignored_bytes();
    test_fragmentation();
    test_tiny_limit_and_abandon();

    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    test_long_hold();
    test_drained_pause();
    test_random_traffic(10, 3, 6);
    test_random_traffic(10, 7, 20);
    test_random_traffic(10, 9000, 9000);
    test_random_traffic(10, 0, 2);

    // Closing stretch with neither side idling.
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    test_random_traffic(15, 5, 5);

    settle();
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- h264_rtp_packetizer.f -----
+incdir+rtl
rtl/rhp_pkg.sv
rtl/rhp_core.sv
rtl/rhp_serializer.sv
rtl/h264_rtp_packetizer.sv
tb/tb_h264_rtp_packetizer.sv
